/* rtl/crast_pkg.sv */
`default_nettype none

package crast_pkg;

  localparam int unsigned CoordWidth   = 16;
  localparam int unsigned DecWidth     = 16;
  localparam int unsigned RadiusWidth  = 13;
  localparam int unsigned ColorWidth   = 16;
  localparam int unsigned InDataWidth  = 64;
  localparam int unsigned OutDataWidth = 64;
  localparam int unsigned BeatIdxWidth = 3;

  localparam logic [DecWidth-1:0] DecStartBias = DecWidth'(3);
  localparam logic [DecWidth-1:0] DecBiasDown  = DecWidth'(10);
  localparam logic [DecWidth-1:0] DecBiasKeep  = DecWidth'(6);

  localparam logic [BeatIdxWidth-1:0] LastBeatOutline = BeatIdxWidth'(7);
  localparam logic [BeatIdxWidth-1:0] LastBeatFill    = BeatIdxWidth'(3);

  typedef enum logic {
    ActStart = 1'b0,
    ActStep  = 1'b1
  } action_e;

  typedef struct packed {
    logic [CoordWidth-1:0] cx;
    logic [CoordWidth-1:0] cy;
    logic [CoordWidth-1:0] x;
    logic [CoordWidth-1:0] y;
    logic [ColorWidth-1:0] color;
    logic                  fill;
    logic                  fin;
  } burst_t;

endpackage

`default_nettype wire

/* rtl/crast_step.sv */
`default_nettype none

module crast_step (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  accept_i,
  input  crast_pkg::action_e                   action_i,
  input  wire  [crast_pkg::CoordWidth-1:0]     center_x_i,
  input  wire  [crast_pkg::CoordWidth-1:0]     center_y_i,
  input  wire  [crast_pkg::RadiusWidth-1:0]    radius_i,
  input  wire                                  fill_mode_i,
  input  wire  [crast_pkg::ColorWidth-1:0]     color_i,
  output logic                                 burst_load_o,
  output crast_pkg::burst_t                    burst_o
);

  logic [crast_pkg::CoordWidth-1:0] x_q, x_d, y_q, y_d, cx_q, cx_d, cy_q, cy_d;
  logic [crast_pkg::CoordWidth-1:0] x_inc, y_dec;
  logic [crast_pkg::DecWidth-1:0]   dec_q, dec_d;
  logic [crast_pkg::ColorWidth-1:0] color_q, color_d;
  logic                             fill_q, fill_d, active_q, active_d;
  logic                             done;

  assign done  = !active_q || (y_q <= x_q);
  assign x_inc = x_q + crast_pkg::CoordWidth'(1);
  assign y_dec = y_q - crast_pkg::CoordWidth'(1);

  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    dec_d    = dec_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    color_d  = color_q;
    fill_d   = fill_q;
    active_d = active_q;
    if (accept_i) begin
      case (action_i)
        crast_pkg::ActStart: begin
          cx_d     = center_x_i;
          cy_d     = center_y_i;
          color_d  = color_i;
          fill_d   = fill_mode_i;
          x_d      = '0;
          y_d      = crast_pkg::CoordWidth'(radius_i);
          dec_d    = crast_pkg::DecStartBias - crast_pkg::DecWidth'({radius_i, 1'b0});
          active_d = 1'b1;
        end
        crast_pkg::ActStep: begin
          if (done) begin
            active_d = 1'b0;
          end else begin
            x_d = x_inc;
            if (!dec_q[crast_pkg::DecWidth-1]) begin
              y_d   = y_dec;
              dec_d = dec_q + crast_pkg::DecWidth'({x_inc, 2'b00})
                      - crast_pkg::DecWidth'({y_dec, 2'b00}) + crast_pkg::DecBiasDown;
            end else begin
              dec_d = dec_q + crast_pkg::DecWidth'({x_inc, 2'b00})
                      + crast_pkg::DecBiasKeep;
            end
          end
        end
        default: begin
          active_d = active_q;
        end
      endcase
    end
  end

  always_comb begin
    burst_load_o   = accept_i && (action_i == crast_pkg::ActStep);
    burst_o.cx     = cx_q;
    burst_o.cy     = cy_q;
    burst_o.x      = x_q;
    burst_o.y      = y_q;
    burst_o.color  = color_q;
    burst_o.fill   = fill_q;
    burst_o.fin    = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      dec_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      color_q  <= '0;
      fill_q   <= 1'b0;
      active_q <= 1'b0;
    end else begin
      x_q      <= x_d;
      y_q      <= y_d;
      dec_q    <= dec_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      color_q  <= color_d;
      fill_q   <= fill_d;
      active_q <= active_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/crast_emit.sv */
`default_nettype none

module crast_emit (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  load_i,
  input  crast_pkg::burst_t                    burst_i,
  input  wire                                  take_i,
  output logic                                 valid_o,
  output logic                                 last_o,
  output logic                                 free_o,
  output logic [crast_pkg::CoordWidth-1:0]     span_x_from_o,
  output logic [crast_pkg::CoordWidth-1:0]     span_x_to_o,
  output logic [crast_pkg::CoordWidth-1:0]     span_row_o,
  output logic [crast_pkg::ColorWidth-1:0]     color_out_o,
  output logic                                 finished_o
);

  crast_pkg::burst_t                  burst_q, burst_d;
  logic                               valid_q, valid_d;
  logic [crast_pkg::BeatIdxWidth-1:0] idx_q, idx_d;
  logic                               swap, row_neg, col_neg;
  logic [crast_pkg::CoordWidth-1:0]   a, b, col_pos, col_neg_v, row_v, from_v;

  always_comb begin
    swap      = burst_q.fill ? idx_q[1] : idx_q[2];
    row_neg   = burst_q.fill ? idx_q[0] : idx_q[1];
    col_neg   = idx_q[0];
    a         = swap ? burst_q.y : burst_q.x;
    b         = swap ? burst_q.x : burst_q.y;
    col_pos   = burst_q.cx + a;
    col_neg_v = burst_q.cx - a;
    row_v     = row_neg ? (burst_q.cy - b) : (burst_q.cy + b);
    from_v    = (burst_q.fill || !col_neg) ? col_pos : col_neg_v;
  end

  always_comb begin
    finished_o = burst_q.fin;
    if (burst_q.fin) begin
      span_x_from_o = '0;
      span_x_to_o   = '0;
      span_row_o    = '0;
      color_out_o   = '0;
      last_o        = 1'b1;
    end else begin
      span_x_from_o = from_v;
      span_x_to_o   = burst_q.fill ? col_neg_v : from_v;
      span_row_o    = row_v;
      color_out_o   = burst_q.color;
      last_o        = burst_q.fill ? (idx_q == crast_pkg::LastBeatFill)
                                   : (idx_q == crast_pkg::LastBeatOutline);
    end
    valid_o = valid_q;
    free_o  = !valid_q || (take_i && last_o);
  end

  always_comb begin
    burst_d = burst_q;
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      burst_d = burst_i;
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (valid_q && take_i) begin
      if (last_o) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + crast_pkg::BeatIdxWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    burst_q <= burst_d;
  end

endmodule

`default_nettype wire

/* rtl/circle_rasterizer_unit.sv */
// Channel   Dir  tdata (low bit up)                                    tuser      tlast
// s_axis    in   center_x 16, center_y 16, radius 13, fill_mode 1,     action     -
//                color 16, zero 2
// m_axis    out  span_x_from 16, span_x_to 16, span_row 16, color_out 16 finished last
//
// A start transfer loads the circle and gives no result.
// A step transfer gives 8 outline points or 4 fill spans, one per cycle while m_axis
// tready is high, or one finished transfer; a single span register emits them.
// The next step is taken in the cycle its predecessor's last result is taken.
// Reset clears the circle state to idle and drops any pending result.
// m_axis holds its transfer while tready is low.
`default_nettype none

module circle_rasterizer_unit (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [crast_pkg::InDataWidth-1:0]   s_axis_tdata,  // center_x, center_y, radius, fill_mode, color
  input  wire                                 s_axis_tuser,  // action
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [crast_pkg::OutDataWidth-1:0]  m_axis_tdata,  // span_x_from, span_x_to, span_row, color_out
  output logic                                m_axis_tuser,  // finished
  output logic                                m_axis_tlast   // last
);

  localparam int unsigned CyLo    = crast_pkg::CoordWidth;
  localparam int unsigned RadLo   = 2 * crast_pkg::CoordWidth;
  localparam int unsigned FillLo  = RadLo + crast_pkg::RadiusWidth;
  localparam int unsigned ColorLo = FillLo + 1;

  logic                               in_accept, free, burst_load;
  crast_pkg::action_e                 action;
  crast_pkg::burst_t                  burst;
  logic [crast_pkg::CoordWidth-1:0]   span_x_from, span_x_to, span_row;
  logic [crast_pkg::ColorWidth-1:0]   color_out;

  assign s_axis_tready = free;
  assign in_accept     = s_axis_tvalid && free;
  assign action        = crast_pkg::action_e'(s_axis_tuser);

  crast_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .action_i    (action),
    .center_x_i  (s_axis_tdata[CyLo-1:0]),
    .center_y_i  (s_axis_tdata[RadLo-1:CyLo]),
    .radius_i    (s_axis_tdata[FillLo-1:RadLo]),
    .fill_mode_i (s_axis_tdata[FillLo]),
    .color_i     (s_axis_tdata[ColorLo+crast_pkg::ColorWidth-1:ColorLo]),
    .burst_load_o(burst_load),
    .burst_o     (burst)
  );

  crast_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (burst_load),
    .burst_i      (burst),
    .take_i       (m_axis_tready),
    .valid_o      (m_axis_tvalid),
    .last_o       (m_axis_tlast),
    .free_o       (free),
    .span_x_from_o(span_x_from),
    .span_x_to_o  (span_x_to),
    .span_row_o   (span_row),
    .color_out_o  (color_out),
    .finished_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {color_out, span_row, span_x_to, span_x_from};

endmodule

`default_nettype wire

/* rtl/crast_checker.sv */
`default_nettype none

module crast_checker (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 s_axis_tvalid,
  input wire                                 s_axis_tready,
  input wire                                 s_axis_tuser,
  input wire                                 m_axis_tvalid,
  input wire                                 m_axis_tready,
  input wire [crast_pkg::OutDataWidth-1:0]   m_axis_tdata,
  input wire                                 m_axis_tuser,
  input wire                                 m_axis_tlast
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("finished transfer not last or carries data");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken mid burst");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("start produced a result");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s_axis_tuser |=> m_axis_tvalid)
    else $error("step produced no result");

endmodule

bind circle_rasterizer_unit crast_checker u_crast_checker (.*);

`default_nettype wire

/* verif/tb_circle_rasterizer_unit.sv */
`default_nettype none

module tb_circle_rasterizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import crast_pkg::*;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned RandomItems  = 330;
  localparam int unsigned NumDirected  = 24;

  typedef struct packed {
    action_e                action;
    logic [CoordWidth-1:0]  cx;
    logic [CoordWidth-1:0]  cy;
    logic [RadiusWidth-1:0] radius;
    logic                   fill;
    logic [ColorWidth-1:0]  color;
  } circle_item_t;

  typedef struct packed {
    logic         typed;
    circle_item_t item;
  } dir_row_t;

  typedef struct packed {
    logic [CoordWidth-1:0] x_from;
    logic [CoordWidth-1:0] x_to;
    logic [CoordWidth-1:0] row;
    logic [ColorWidth-1:0] color;
    logic                  fin;
    logic                  lst;
  } span_t;

  localparam span_t DoneSpan = '{x_from: '0, x_to: '0, row: '0, color: '0, fin: 1'b1, lst: 1'b1};

  // typed rows expect the finished transfer
  localparam dir_row_t DirRows [NumDirected] = '{
    '{1'b1, '{ActStep,  16'hFFFF, 16'hFFFF, 13'h1FFF, 1'b1, 16'hFFFF}},
    '{1'b0, '{ActStart, 16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b1, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b1, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b0, '{ActStart, 16'hFFFF, 16'hFFFF, 13'h1FFF, 1'b1, 16'hFFFF}},
    '{1'b0, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b0, '{ActStep,  16'hFFFF, 16'hFFFF, 13'h1FFF, 1'b1, 16'hFFFF}},
    '{1'b0, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b0, '{ActStart, 16'h0000, 16'h0000, 13'h1FFF, 1'b0, 16'h0000}},
    '{1'b0, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b0, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b0, '{ActStart, 16'h0100, 16'h0200, 13'h0001, 1'b0, 16'hA5A5}},
    '{1'b0, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b0, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b0, '{ActStart, 16'h8000, 16'h7FFF, 13'h0003, 1'b1, 16'h5A5A}},
    '{1'b0, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b0, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b1, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b1, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b0, '{ActStart, 16'h1234, 16'h4321, 13'h0002, 1'b0, 16'h0F0F}},
    '{1'b0, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b0, '{ActStart, 16'h0005, 16'hFFFB, 13'h000A, 1'b1, 16'h8001}},
    '{1'b0, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}},
    '{1'b0, '{ActStep,  16'h0000, 16'h0000, 13'h0000, 1'b0, 16'h0000}}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata = '0;
  logic                    s_axis_tuser = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    m_axis_tlast;

  logic [CoordWidth-1:0] cur_x, cur_y, cur_dec, ctr_col, ctr_row;
  logic [ColorWidth-1:0] pen_color;
  logic                  fill_on, running;

  span_t       pending_spans[$];
  span_t       step_spans[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;

  circle_rasterizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void add_span(input logic [CoordWidth-1:0] a, input logic [CoordWidth-1:0] b,
                                   input logic [CoordWidth-1:0] r);
    step_spans.push_back('{x_from: a, x_to: b, row: r, color: pen_color, fin: 1'b0, lst: 1'b0});
  endfunction

  task automatic predict_spans(input circle_item_t it);
    logic [CoordWidth-1:0] cx, cy, x, y;
    step_spans.delete();
    if (it.action == ActStart) begin
      ctr_col   = it.cx;
      ctr_row   = it.cy;
      fill_on   = it.fill;
      pen_color = it.color;
      cur_x     = '0;
      cur_y     = CoordWidth'(it.radius);
      cur_dec   = DecStartBias - {2'b00, it.radius, 1'b0};
      running   = 1'b1;
    end else if (!running || cur_y <= cur_x) begin
      running = 1'b0;
      step_spans.push_back(DoneSpan);
    end else begin
      cx = ctr_col;
      cy = ctr_row;
      x  = cur_x;
      y  = cur_y;
      if (fill_on) begin
        add_span(cx + x, cx - x, cy + y);
        add_span(cx + x, cx - x, cy - y);
        add_span(cx + y, cx - y, cy + x);
        add_span(cx + y, cx - y, cy - x);
      end else begin
        add_span(cx + x, cx + x, cy + y);
        add_span(cx - x, cx - x, cy + y);
        add_span(cx + x, cx + x, cy - y);
        add_span(cx - x, cx - x, cy - y);
        add_span(cx + y, cx + y, cy + x);
        add_span(cx - y, cx - y, cy + x);
        add_span(cx + y, cx + y, cy - x);
        add_span(cx - y, cx - y, cy - x);
      end
      step_spans[step_spans.size()-1].lst = 1'b1;
      cur_x = x + 1'b1;
      if (!cur_dec[DecWidth-1]) begin
        cur_y   = y - 1'b1;
        cur_dec = cur_dec + (cur_x << 2) - (cur_y << 2) + DecBiasDown;
      end else begin
        cur_dec = cur_dec + (cur_x << 2) + DecBiasKeep;
      end
    end
  endtask

  task automatic send_item(input circle_item_t it, input logic typed);
    int unsigned gap;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, it.color, it.fill, it.radius, it.cy, it.cx};
    s_axis_tuser  = it.action;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_spans(it);
    if (typed) begin
      pending_spans.push_back(DoneSpan);
    end else begin
      foreach (step_spans[i]) pending_spans.push_back(step_spans[i]);
    end
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 7);
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain_spans();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic circle_item_t rand_item(input action_e act);
    circle_item_t it;
    it.action = act;
    it.cx     = CoordWidth'($urandom);
    it.cy     = CoordWidth'($urandom);
    it.radius = RadiusWidth'($urandom);
    it.fill   = 1'($urandom);
    it.color  = ColorWidth'($urandom);
    return it;
  endfunction

  initial begin
    int          stall_phase;
    int unsigned mode;
    stall_phase = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 120)) begin
        @(negedge clk_i);
        stall_phase++;
        case (mode)
          0: begin
            m_axis_tready = 1'b1;
          end
          1: begin
            m_axis_tready = ($urandom_range(0, 3) != 0);
          end
          2: begin
            m_axis_tready = 1'($urandom);
          end
          default: begin
            m_axis_tready = (stall_phase % 5 == 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    span_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_spans.size() == 0) begin
        $error("unexpected result transfer: tdata %h tuser %b tlast %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatch_cnt++;
      end else begin
        want = pending_spans.pop_front();
        if (m_axis_tdata[15:0] !== want.x_from) begin
          $error("span_x_from: expected %h, actual %h", want.x_from, m_axis_tdata[15:0]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[31:16] !== want.x_to) begin
          $error("span_x_to: expected %h, actual %h", want.x_to, m_axis_tdata[31:16]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[47:32] !== want.row) begin
          $error("span_row: expected %h, actual %h", want.row, m_axis_tdata[47:32]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[63:48] !== want.color) begin
          $error("color_out: expected %h, actual %h", want.color, m_axis_tdata[63:48]);
          mismatch_cnt++;
        end
        if (m_axis_tuser !== want.fin) begin
          $error("finished: expected %b, actual %b", want.fin, m_axis_tuser);
          mismatch_cnt++;
        end
        if (m_axis_tlast !== want.lst) begin
          $error("last: expected %b, actual %b", want.lst, m_axis_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    circle_item_t it;
    int unsigned  n_steps;
    int unsigned  rnd_count;
    logic         paused;
    ctr_col   = '0;
    ctr_row   = '0;
    cur_x     = '0;
    cur_y     = '0;
    cur_dec   = '0;
    pen_color = '0;
    fill_on   = 1'b0;
    running   = 1'b0;
    paused    = 1'b0;
    burst_left = $urandom_range(1, 12);
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumDirected; i++) send_item(DirRows[i].item, DirRows[i].typed);
    drain_spans();

    rnd_count = 0;
    while (rnd_count < RandomItems) begin
      if (!paused && rnd_count >= RandomItems / 2) begin
        // hold off until the pipeline is empty
        drain_spans();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 8) begin
        it = rand_item(ActStart);
        if ($urandom_range(0, 14) == 0) begin
          it.radius = RadiusWidth'($urandom_range(4096, 8191));
          n_steps   = $urandom_range(1, 6);
        end else begin
          it.radius = RadiusWidth'($urandom_range(0, 24));
          n_steps   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, it.radius)
                                                  : (it.radius * 3) / 4 + 2;
        end
        send_item(it, 1'b0);
        rnd_count++;
        repeat (n_steps) begin
          send_item(rand_item(ActStep), 1'b0);
          rnd_count++;
        end
      end else begin
        it = rand_item(action_e'(1'($urandom)));
        if (it.action == ActStart) it.radius = RadiusWidth'($urandom_range(0, 24));
        send_item(it, 1'b0);
        rnd_count++;
      end
    end
    drain_spans();

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
